// ===== sv/lcf_pkg.sv =====
package lcf_pkg;

  localparam int unsigned NumLedsDefault = 8;

  localparam int unsigned PwmW    = 7;
  localparam int unsigned IntW    = 8;
  localparam int unsigned DelayW  = 10;
  localparam int unsigned SampleW = 12;
  localparam int unsigned ProdW   = SampleW + DelayW;
  localparam int unsigned HoldW   = 11;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned DriveW  = 8;
  localparam int unsigned IndexW  = 3;

  localparam logic [PwmW-1:0]   PwmPeriodReset    = 7'd100;
  localparam logic [IntW-1:0]   AnimIntervalReset = 8'd5;
  localparam logic [PwmW-1:0]   FadeDownReset     = 7'd8;
  localparam logic [PwmW-1:0]   FadeUpReset       = 7'd10;
  localparam logic [IntW-1:0]   DebounceReset     = 8'd20;
  localparam logic [IntW-1:0]   AdcIntervalReset  = 8'd20;
  localparam logic [DelayW-1:0] DelayBaseReset    = 10'd50;
  localparam logic [DelayW-1:0] DelaySpanReset    = 10'd450;
  localparam logic [HoldW-1:0]  HoldDelayReset    = 11'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPwmPeriod,
    CfgAnimInterval,
    CfgFadeDown,
    CfgFadeUp,
    CfgDebounce,
    CfgAdcInterval,
    CfgDelayBase,
    CfgDelaySpan
  } cfg_idx_e;

  typedef struct packed {
    logic [PwmW-1:0]   pwm_period;
    logic [IntW-1:0]   anim_interval;
    logic [PwmW-1:0]   fade_down;
    logic [PwmW-1:0]   fade_up;
    logic [IntW-1:0]   debounce;
    logic [IntW-1:0]   adc_interval;
    logic [DelayW-1:0] delay_base;
    logic [DelayW-1:0] delay_span;
  } cfg_t;

  typedef struct packed {
    logic             ms_strobe;
    logic             button_level;
    logic             adc_valid;
    logic [ProdW-1:0] product;
  } item_t;

endpackage

// ===== sv/lcf_cfg.sv =====
module lcf_cfg import lcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPwmPeriod:    cfg_d.pwm_period    = cfg_data_i[PwmW-1:0];
        CfgAnimInterval: cfg_d.anim_interval = cfg_data_i[IntW-1:0];
        CfgFadeDown:     cfg_d.fade_down     = cfg_data_i[PwmW-1:0];
        CfgFadeUp:       cfg_d.fade_up       = cfg_data_i[PwmW-1:0];
        CfgDebounce:     cfg_d.debounce      = cfg_data_i[IntW-1:0];
        CfgAdcInterval:  cfg_d.adc_interval  = cfg_data_i[IntW-1:0];
        CfgDelayBase:    cfg_d.delay_base    = cfg_data_i[DelayW-1:0];
        CfgDelaySpan:    cfg_d.delay_span    = cfg_data_i[DelayW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period    <= PwmPeriodReset;
      cfg_q.anim_interval <= AnimIntervalReset;
      cfg_q.fade_down     <= FadeDownReset;
      cfg_q.fade_up       <= FadeUpReset;
      cfg_q.debounce      <= DebounceReset;
      cfg_q.adc_interval  <= AdcIntervalReset;
      cfg_q.delay_base    <= DelayBaseReset;
      cfg_q.delay_span    <= DelaySpanReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/lcf_front.sv =====
module lcf_front import lcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic               ms_strobe_i,
  input  logic               button_level_i,
  input  logic [SampleW-1:0] adc_sample_i,
  input  logic               adc_valid_i,
  input  logic [DelayW-1:0]  delay_span_i,
  output logic               item_vld_o,
  output item_t              item_o
);

  logic               a_vld_q;
  logic               a_ms_q;
  logic               a_btn_q;
  logic [SampleW-1:0] a_sample_q;
  logic               a_adc_vld_q;
  logic               b_vld_q;
  item_t              b_item_q;
  item_t              b_item_d;

  always_comb begin
    b_item_d.ms_strobe    = a_ms_q;
    b_item_d.button_level = a_btn_q;
    b_item_d.adc_valid    = a_adc_vld_q;
    b_item_d.product      = {{DelayW{1'b0}}, a_sample_q} * {{SampleW{1'b0}}, delay_span_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ms_q      <= ms_strobe_i;
      a_btn_q     <= button_level_i;
      a_sample_q  <= adc_sample_i;
      a_adc_vld_q <= adc_valid_i;
      b_item_q    <= b_item_d;
    end
  end

  assign item_vld_o = b_vld_q;
  assign item_o     = b_item_q;

endmodule

// ===== sv/lcf_engine.sv =====
module lcf_engine import lcf_pkg::*; #(
  parameter int unsigned NUM_LEDS = NumLedsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              en_i,
  input  logic              item_vld_i,
  input  item_t             item_i,
  output logic              out_vld_o,
  output logic [DriveW-1:0] led_drive_o,
  output logic [IndexW-1:0] active_index_o,
  output logic              reverse_flag_o
);

  localparam int unsigned IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned DrvN = (NUM_LEDS < DriveW) ? NUM_LEDS : DriveW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LEDS - 1);

  logic [PwmW-1:0]  pwm_q, pwm_d;
  logic [PwmW-1:0]  bright_q [NUM_LEDS];
  logic [PwmW-1:0]  bright_d [NUM_LEDS];
  logic [IdxW-1:0]  active_q, active_d;
  logic             reverse_q, reverse_d;
  logic             stable_q, stable_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [TimeW-1:0] anim_mark_q, anim_mark_d;
  logic [TimeW-1:0] adc_mark_q, adc_mark_d;
  logic [TimeW-1:0] hold_mark_q, hold_mark_d;
  logic [TimeW-1:0] btn_mark_q, btn_mark_d;

  logic              out_vld_q;
  logic [DriveW-1:0] drive_q, drive_d;
  logic [IndexW-1:0] idx_q;
  logic              rev_q;

  logic [TimeW-1:0]   now_inc;
  logic [TimeW-1:0]   d_anim, d_adc, d_hold, d_btn;
  logic [ProdW:0]     quot_t;
  logic [HoldW-1:0]   delay_cand;
  logic [PwmW-1:0]    act_b;
  logic [PwmW:0]      ramp;
  logic [PwmW:0]      pwm_nxt;
  logic [IdxW-1:0]    step_idx;
  logic [IdxW+IndexW-1:0] idx_ext;

  assign now_inc = now_q + 1'b1;
  assign d_anim  = now_inc - anim_mark_q;
  assign d_adc   = now_inc - adc_mark_q;
  assign d_hold  = now_inc - hold_mark_q;
  assign d_btn   = now_inc - btn_mark_q;

  // exact floor(p / 4095) for p below 2^22
  assign quot_t     = {1'b0, item_i.product} + (ProdW+1)'(item_i.product >> SampleW) +
                      (ProdW+1)'(1);
  assign delay_cand = HoldW'(cfg_i.delay_base) + HoldW'(quot_t[SampleW+DelayW-1:SampleW]);

  assign act_b = bright_q[active_q];
  assign ramp  = {1'b0, act_b} + {1'b0, cfg_i.fade_up};

  always_comb begin
    if (reverse_d) begin
      step_idx = (active_q == '0) ? LastIdx : active_q - 1'b1;
    end else begin
      step_idx = (active_q == LastIdx) ? '0 : active_q + 1'b1;
    end
  end

  always_comb begin
    pwm_d       = pwm_q;
    bright_d    = bright_q;
    active_d    = active_q;
    reverse_d   = reverse_q;
    stable_d    = stable_q;
    hold_d      = hold_q;
    now_d       = now_q;
    anim_mark_d = anim_mark_q;
    adc_mark_d  = adc_mark_q;
    hold_mark_d = hold_mark_q;
    btn_mark_d  = btn_mark_q;
    pwm_nxt     = {1'b0, pwm_q} + 1'b1;
    drive_d     = '0;

    if (item_vld_i && item_i.ms_strobe) begin
      now_d = now_inc;
      if ((item_i.button_level != stable_q) && (d_btn >= TimeW'(cfg_i.debounce))) begin
        btn_mark_d = now_inc;
        stable_d   = item_i.button_level;
        if (!item_i.button_level) begin
          reverse_d = ~reverse_q;
        end
      end
      if (d_adc >= TimeW'(cfg_i.adc_interval)) begin
        adc_mark_d = now_inc;
        if (item_i.adc_valid) begin
          hold_d = delay_cand;
        end
      end
      if (d_anim >= TimeW'(cfg_i.anim_interval)) begin
        anim_mark_d = now_inc;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (IdxW'(i) != active_q) begin
            bright_d[i] = (bright_q[i] > cfg_i.fade_down) ? bright_q[i] - cfg_i.fade_down : '0;
          end
        end
        if (act_b < cfg_i.pwm_period) begin
          bright_d[active_q] = (ramp > {1'b0, cfg_i.pwm_period}) ? cfg_i.pwm_period :
                                                                   ramp[PwmW-1:0];
          hold_mark_d = now_inc;
        end else if (d_hold >= TimeW'(hold_d)) begin
          active_d           = step_idx;
          bright_d[step_idx] = '0;
          hold_mark_d        = now_inc;
        end
      end
    end

    if (item_vld_i) begin
      pwm_d = (pwm_nxt >= {1'b0, cfg_i.pwm_period}) ? '0 : pwm_nxt[PwmW-1:0];
    end

    for (int i = 0; i < DrvN; i++) begin
      drive_d[i] = (pwm_d < bright_d[i]);
    end
  end

  assign idx_ext = {{IndexW{1'b0}}, active_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q       <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        bright_q[i] <= '0;
      end
      active_q    <= '0;
      reverse_q   <= 1'b0;
      stable_q    <= 1'b1;
      hold_q      <= HoldDelayReset;
      now_q       <= '0;
      anim_mark_q <= '0;
      adc_mark_q  <= '0;
      hold_mark_q <= '0;
      btn_mark_q  <= '0;
      out_vld_q   <= 1'b0;
    end else if (en_i) begin
      pwm_q       <= pwm_d;
      bright_q    <= bright_d;
      active_q    <= active_d;
      reverse_q   <= reverse_d;
      stable_q    <= stable_d;
      hold_q      <= hold_d;
      now_q       <= now_d;
      anim_mark_q <= anim_mark_d;
      adc_mark_q  <= adc_mark_d;
      hold_mark_q <= hold_mark_d;
      btn_mark_q  <= btn_mark_d;
      out_vld_q   <= item_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && item_vld_i) begin
      drive_q <= drive_d;
      idx_q   <= idx_ext[IndexW-1:0];
      rev_q   <= reverse_d;
    end
  end

  assign out_vld_o      = out_vld_q;
  assign led_drive_o    = drive_q;
  assign active_index_o = idx_q;
  assign reverse_flag_o = rev_q;

endmodule

// ===== sv/led_chaser_fade_pwm_core.sv =====
// LED chaser with PWM fade. Each input word is one 100 us PWM tick and gives
// exactly one output word carrying the LED drive pattern for that tick, the
// active LED number and the chase direction. One word is taken every clock
// unless the result is stalled; a word's result is valid once it has passed
// three register stages (input register, sample-times-span product register,
// result register). A stalled result holds the whole pipe and the input with
// it. The whole tick update (debounce, scaling division of the ADC sample,
// fade animation, chase step, PWM count) is combinational logic in a loop
// around the state registers. Configuration writes take effect once registered
// and are only to be made while no word is in flight.
module led_chaser_fade_pwm_core import lcf_pkg::*; #(
  parameter int unsigned NUM_LEDS = NumLedsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] ms_strobe, [1] button_level, [13:2] adc_sample, [14] adc_valid
  input  logic [15:0]         s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] led_drive, [10:8] active_index, [11] reverse_flag
  output logic [15:0]         m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg;
  logic              en;
  logic              item_vld;
  item_t             item;
  logic              out_vld;
  logic [DriveW-1:0] led_drive;
  logic [IndexW-1:0] active_index;
  logic              reverse_flag;

  assign en              = ~out_vld | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {4'b0, reverse_flag, active_index, led_drive};

  lcf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .in_valid_i     (s_axis_tvalid_i),
    .ms_strobe_i    (s_axis_tdata_i[0]),
    .button_level_i (s_axis_tdata_i[1]),
    .adc_sample_i   (s_axis_tdata_i[13:2]),
    .adc_valid_i    (s_axis_tdata_i[14]),
    .delay_span_i   (cfg.delay_span),
    .item_vld_o     (item_vld),
    .item_o         (item)
  );

  lcf_engine #(
    .NUM_LEDS (NUM_LEDS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .en_i           (en),
    .item_vld_i     (item_vld),
    .item_i         (item),
    .out_vld_o      (out_vld),
    .led_drive_o    (led_drive),
    .active_index_o (active_index),
    .reverse_flag_o (reverse_flag)
  );

endmodule

// ===== bench/lcf_checker.sv =====
`timescale 1ns / 1ps

module lcf_checker import lcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // [0] ms_strobe, [1] button_level, [13:2] adc_sample, [14] adc_valid
  input  logic [15:0]         s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // [7:0] led_drive, [10:8] active_index, [11] reverse_flag
  input  logic [15:0]         m_tdata_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fails_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic              rev;
    logic [IndexW-1:0] index;
    logic [DriveW-1:0] drive;
  } lamp_t;

  cfg_t            cfg;
  logic [PwmW-1:0] pwm_cnt;
  logic [PwmW-1:0] bright [8];
  logic [2:0]      act;
  logic            rev;
  logic            btn_stable;
  logic [HoldW-1:0] hold;
  logic [TimeW-1:0] now_ms, t_anim, t_adc, t_hold, t_btn;
  lamp_t           lamp_due [$];

  function automatic void clear_state();
    cfg = '{PwmPeriodReset, AnimIntervalReset, FadeDownReset, FadeUpReset,
            DebounceReset, AdcIntervalReset, DelayBaseReset, DelaySpanReset};
    pwm_cnt = '0;
    foreach (bright[i]) bright[i] = '0;
    act = '0;
    rev = 1'b0;
    btn_stable = 1'b1;
    hold = HoldDelayReset;
    now_ms = '0;
    t_anim = '0;
    t_adc = '0;
    t_hold = '0;
    t_btn = '0;
    lamp_due.delete();
    fails_o = 0;
  endfunction

  function automatic void write_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] d);
    case (cfg_idx_e'(idx))
      CfgPwmPeriod:    cfg.pwm_period    = d[PwmW-1:0];
      CfgAnimInterval: cfg.anim_interval = d[IntW-1:0];
      CfgFadeDown:     cfg.fade_down     = d[PwmW-1:0];
      CfgFadeUp:       cfg.fade_up       = d[PwmW-1:0];
      CfgDebounce:     cfg.debounce      = d[IntW-1:0];
      CfgAdcInterval:  cfg.adc_interval  = d[IntW-1:0];
      CfgDelayBase:    cfg.delay_base    = d[DelayW-1:0];
      CfgDelaySpan:    cfg.delay_span    = d[DelayW-1:0];
      default: ;
    endcase
  endfunction

  function automatic lamp_t advance_tick(input logic [15:0] w);
    logic             ms, btn, ok;
    logic [SampleW-1:0] adc;
    int unsigned      b, nxt;
    int               i;
    lamp_t            o;
    ms  = w[0];
    btn = w[1];
    adc = w[13:2];
    ok  = w[14];
    if (ms) begin
      now_ms = now_ms + 32'd1;
      if (btn != btn_stable && (now_ms - t_btn) >= 32'(cfg.debounce)) begin
        t_btn = now_ms;
        btn_stable = btn;
        if (!btn) rev = ~rev;
      end
      if ((now_ms - t_adc) >= 32'(cfg.adc_interval)) begin
        t_adc = now_ms;
        if (ok)
          hold = 11'(32'(cfg.delay_base) + 32'(adc) * 32'(cfg.delay_span) / 32'd4095);
      end
      if ((now_ms - t_anim) >= 32'(cfg.anim_interval)) begin
        t_anim = now_ms;
        for (i = 0; i < 8; i++) begin
          if (3'(i) != act)
            bright[i] = (bright[i] > cfg.fade_down) ? bright[i] - cfg.fade_down : '0;
        end
        b = bright[act];
        if (b < cfg.pwm_period) begin
          b = b + cfg.fade_up;
          bright[act] = (b > cfg.pwm_period) ? cfg.pwm_period : 7'(b);
          t_hold = now_ms;
        end else if ((now_ms - t_hold) >= 32'(hold)) begin
          act = rev ? act - 3'd1 : act + 3'd1;
          bright[act] = '0;
          t_hold = now_ms;
        end
      end
    end
    nxt = pwm_cnt + 1;
    pwm_cnt = (nxt >= cfg.pwm_period) ? '0 : 7'(nxt);
    for (i = 0; i < 8; i++) o.drive[i] = pwm_cnt < bright[i];
    o.index = act;
    o.rev = rev;
    return o;
  endfunction

  function automatic void check_word(input logic [15:0] w);
    lamp_t want;
    if (lamp_due.size() == 0) begin
      $display("%0t: word %h with none expected", $time, w);
      fails_o++;
    end else begin
      want = lamp_due.pop_front();
      if (w[7:0] !== want.drive) begin
        $display("%0t: led_drive expected %h got %h", $time, want.drive, w[7:0]);
        fails_o++;
      end
      if (w[10:8] !== want.index) begin
        $display("%0t: active_index expected %0d got %0d", $time, want.index, w[10:8]);
        fails_o++;
      end
      if (w[11] !== want.rev) begin
        $display("%0t: reverse_flag expected %b got %b", $time, want.rev, w[11]);
        fails_o++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (m_tvalid_i && m_tready_i) check_word(m_tdata_i);
      if (cfg_valid_i && cfg_ready_i) write_cfg(cfg_index_i, cfg_data_i);
      if (s_tvalid_i && s_tready_i) lamp_due.push_back(advance_tick(s_tdata_i));
    end
    pending_o = lamp_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import lcf_pkg::*;;

  logic                clk, rst_n;
  logic                s_valid, s_ready;
  logic [15:0]         s_data;
  logic                m_valid, m_ready;
  logic [15:0]         m_data;
  logic                cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fails, pending;
  bit                  tx_idle, rx_idle;
  logic                btn_hold;

  led_chaser_fade_pwm_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  lcf_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stall before each word while rx_idle is set
  initial begin
    int gap;
    m_ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = rx_idle ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        @(negedge clk);
        m_ready <= 1'b0;
      end
      @(negedge clk);
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  task automatic send_tick(input logic ms, input logic btn, input logic ok,
                           input logic [SampleW-1:0] adc);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, ok, adc, btn, ms};
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    drain();
    write_reg(CfgPwmPeriod,    10'(s.pwm_period));
    write_reg(CfgAnimInterval, 10'(s.anim_interval));
    write_reg(CfgFadeDown,     10'(s.fade_down));
    write_reg(CfgFadeUp,       10'(s.fade_up));
    write_reg(CfgDebounce,     10'(s.debounce));
    write_reg(CfgAdcInterval,  10'(s.adc_interval));
    write_reg(CfgDelayBase,    s.delay_base);
    write_reg(CfgDelaySpan,    s.delay_span);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t rand_settings(input bit wide);
    cfg_t s;
    s.pwm_period = 7'($urandom_range(0, 127));
    s.fade_down  = 7'($urandom_range(1, 127));
    s.fade_up    = 7'($urandom_range(1, 127));
    if (wide) begin
      s.anim_interval = 8'($urandom);
      s.debounce      = 8'($urandom);
      s.adc_interval  = 8'($urandom);
      s.delay_base    = 10'($urandom);
      s.delay_span    = 10'($urandom);
    end else begin
      s.anim_interval = 8'($urandom_range(0, 3));
      s.debounce      = 8'($urandom_range(0, 15));
      s.adc_interval  = 8'($urandom_range(0, 7));
      s.delay_base    = 10'($urandom_range(0, 15));
      s.delay_span    = 10'($urandom_range(0, 63));
    end
    return s;
  endfunction

  task automatic run_ticks(input int n, input int strobe_pct, input int flip_pct,
                           input int drain_every);
    logic               ms, ok;
    logic [SampleW-1:0] adc;
    int                 k;
    for (k = 0; k < n; k++) begin
      ms = $urandom_range(0, 99) < strobe_pct;
      if ($urandom_range(0, 99) < flip_pct) btn_hold = ~btn_hold;
      case ($urandom_range(0, 7))
        0:       adc = '0;
        1:       adc = '1;
        default: adc = 12'($urandom);
      endcase
      ok = $urandom_range(0, 7) != 0;
      send_tick(ms, btn_hold, ok, adc);
      if (drain_every != 0 && k % drain_every == drain_every - 1) drain();
    end
  endtask

  initial begin
    int k;
    rst_n     = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgPwmPeriod;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    btn_hold  = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: button held down from the first ms, ADC use at ms 20 is invalid
    send_tick(1'b0, 1'b1, 1'b0, 12'h000);
    send_tick(1'b0, 1'b0, 1'b1, 12'hfff);
    for (k = 2; k < 25; k++) begin
      case (k % 4)
        0: send_tick(1'b1, 1'b0, k % 3 != 0, 12'haaa);
        1: send_tick(1'b1, 1'b0, k % 3 != 0, 12'h555);
        2: send_tick(1'b1, 1'b0, k % 3 != 0, 12'hfff);
        default: send_tick(1'b1, 1'b0, k % 3 != 0, 12'h000);
      endcase
    end
    btn_hold = 1'b0;
    run_ticks(150, 80, 3, 50);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    apply_settings('{7'd16, 8'd1, 7'd5, 7'd127, 8'd2, 8'd1, 10'd0, 10'd10});
    run_ticks(250, 90, 8, 0);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    apply_settings('{7'd127, 8'd1, 7'd3, 7'd9, 8'd0, 8'd1, 10'd3, 10'd20});
    run_ticks(200, 90, 5, 0);

    // period lowered under the brightness and the counter
    apply_settings('{7'd10, 8'd2, 7'd127, 7'd127, 8'd255, 8'd3, 10'd1023, 10'd1023});
    run_ticks(100, 90, 5, 0);

    apply_settings('{7'd1, 8'd0, 7'd1, 7'd1, 8'd0, 8'd0, 10'd0, 10'd0});
    run_ticks(150, 75, 10, 0);

    apply_settings('{7'd0, 8'd0, 7'd2, 7'd3, 8'd1, 8'd0, 10'd0, 10'd5});
    run_ticks(100, 75, 10, 0);

    apply_settings('{7'd127, 8'd255, 7'd127, 7'd1, 8'd255, 8'd255, 10'd1023, 10'd1023});
    run_ticks(60, 90, 5, 0);

    apply_settings('{7'd2, 8'd1, 7'd1, 7'd1, 8'd0, 8'd1, 10'd0, 10'd0});
    run_ticks(150, 85, 6, 0);

    for (k = 0; k < 5; k++) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      apply_settings(rand_settings(k == 4));
      run_ticks(160, $urandom_range(50, 100), (k == 2) ? 50 : $urandom_range(2, 12), 0);
    end

    drain();
    repeat (8) @(negedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lcf_pkg.sv
sv/lcf_cfg.sv
sv/lcf_front.sv
sv/lcf_engine.sv
sv/led_chaser_fade_pwm_core.sv
bench/lcf_checker.sv
bench/tb_top.sv
